// ----- design/phs_pkg.sv -----
// shared types, codes and constants of the pairing handshake sequencer
`timescale 1ns / 1ps
`default_nettype none

package phs_pkg;

   // field widths of the channel words
   localparam int REQ_TYPE_W  = 3;
   localparam int TIME_W      = 32;
   localparam int ADDR_W      = 24;
   localparam int CHAN_W      = 8;
   localparam int COUNT_W     = 8;
   localparam int STATE_W     = 4;
   localparam int STEP_W      = 2;
   localparam int GAP_W       = 16;
   localparam int BACKOFF_W   = 19;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 19;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_INTER_PACKET   = 3'd0,
      CSR_MAX_BACKOFF    = 3'd1,
      CSR_RETRY_LIMIT    = 3'd2,
      CSR_COUNTER_TOP    = 3'd3,
      CSR_DEFAULT_PACKETS = 3'd4
   } csr_index_type;

   // register reset values
   localparam logic [GAP_W-1:0]     INTER_PACKET_RESET    = 16'd10;
   localparam logic [BACKOFF_W-1:0] MAX_BACKOFF_RESET     = 19'd1000;
   localparam logic [COUNT_W-1:0]   RETRY_LIMIT_RESET     = 8'd3;
   localparam logic [COUNT_W-1:0]   COUNTER_TOP_RESET     = 8'd255;
   localparam logic [COUNT_W-1:0]   DEFAULT_PACKETS_RESET = 8'd2;

   // backoff shift: retries below the limit shift by their count, else by the cap
   localparam logic [COUNT_W-1:0] SHIFT_LIMIT = 8'd4;
   localparam logic [1:0]         SHIFT_CAP   = 2'd3;
   localparam logic [COUNT_W-1:0] RETRY_SAT   = 8'd255;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_START        = 3'd0,
      REQ_CONFIRM_UP   = 3'd1,
      REQ_CONFIRM_DOWN = 3'd2,
      REQ_CANCEL       = 3'd3,
      REQ_TX_COMPLETE  = 3'd4,
      REQ_TX_ISSUED    = 3'd5
   } req_op_type;

   typedef enum logic [STATE_W-1:0] {
      PH_IDLE      = 4'd0,
      PH_PROG      = 4'd1,
      PH_WAIT_UP   = 4'd2,
      PH_CONF_UP   = 4'd3,
      PH_WAIT_DOWN = 4'd4,
      PH_CONF_DOWN = 4'd5,
      PH_COMPLETE  = 4'd6,
      PH_FAILED    = 4'd7,
      PH_CANCELLED = 4'd8,
      PH_TIMED_OUT = 4'd9
   } phase_type;

   typedef enum logic [STEP_W-1:0] {
      STEP_NONE = 2'd0,
      STEP_PROG = 2'd1,
      STEP_UP   = 2'd2,
      STEP_DOWN = 2'd3
   } step_type;

   typedef struct packed {
      logic [GAP_W-1:0]     frame_gap;
      logic [BACKOFF_W-1:0] backoff_cap;
      logic [COUNT_W-1:0]   send_retry_limit;
      logic [COUNT_W-1:0]   counter_top;
   } cfg_type;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0] req_type;
      logic [TIME_W-1:0]     now_ms;
      logic [ADDR_W-1:0]     sender_addr;
      logic [CHAN_W-1:0]     channel;
      logic [COUNT_W-1:0]    packets;
      logic [TIME_W-1:0]     session_len;
      logic                  tx_success;
   } req_word_type;

   typedef struct packed {
      logic               accepted;
      phase_type          session_state;
      step_type           step_code;
      logic               program_frame;
      logic [COUNT_W-1:0] frame_counter;
      logic [TIME_W-1:0]  next_attempt_ms;
      logic [TIME_W-1:0]  deadline_ms;
      logic [ADDR_W-1:0]  addr_out;
      logic [CHAN_W-1:0]  channel_out;
   } rsp_word_type;

endpackage

`default_nettype wire

// ----- design/phs_if.sv -----
// request and response channel interfaces of the pairing handshake sequencer
`timescale 1ns / 1ps
`default_nettype none

interface phs_req_if
   import phs_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [TIME_W-1:0]     now_ms;
   logic [ADDR_W-1:0]     sender_addr;
   logic [CHAN_W-1:0]     channel;
   logic [COUNT_W-1:0]    packets;
   logic [TIME_W-1:0]     session_len;
   logic                  tx_success;

   modport source (
      output valid, req_type, now_ms, sender_addr, channel, packets,
             session_len, tx_success,
      input  ready
   );
   modport sink (
      input  valid, req_type, now_ms, sender_addr, channel, packets,
             session_len, tx_success,
      output ready
   );
endinterface

interface phs_rsp_if
   import phs_pkg::*;
();
   logic               valid;
   logic               ready;
   logic               accepted;
   logic [STATE_W-1:0] session_state;
   logic [STEP_W-1:0]  step_code;
   logic               program_frame;
   logic [COUNT_W-1:0] frame_counter;
   logic [TIME_W-1:0]  next_attempt_ms;
   logic [TIME_W-1:0]  deadline_ms;
   logic [ADDR_W-1:0]  addr_out;
   logic [CHAN_W-1:0]  channel_out;

   modport source (
      output valid, accepted, session_state, step_code, program_frame, frame_counter,
             next_attempt_ms, deadline_ms, addr_out, channel_out,
      input  ready
   );
   modport sink (
      input  valid, accepted, session_state, step_code, program_frame, frame_counter,
             next_attempt_ms, deadline_ms, addr_out, channel_out,
      output ready
   );
endinterface

`default_nettype wire

// ----- design/phs_csr.sv -----
// configuration registers of the pairing handshake sequencer
`timescale 1ns / 1ps
`default_nettype none

module phs_csr
   import phs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_INTER_PACKET:    cfg_in.frame_gap        = csr_wdata[GAP_W-1:0];
            CSR_MAX_BACKOFF:     cfg_in.backoff_cap      = csr_wdata[BACKOFF_W-1:0];
            CSR_RETRY_LIMIT:     cfg_in.send_retry_limit = csr_wdata[COUNT_W-1:0];
            CSR_COUNTER_TOP:     cfg_in.counter_top      = csr_wdata[COUNT_W-1:0];
            // default frame count only matters at reset, nothing to hold
            CSR_DEFAULT_PACKETS: cfg_in = cfg_ff;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_gap        <= INTER_PACKET_RESET;
         cfg_ff.backoff_cap      <= MAX_BACKOFF_RESET;
         cfg_ff.send_retry_limit <= RETRY_LIMIT_RESET;
         cfg_ff.counter_top      <= COUNTER_TOP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- design/phs_core.sv -----
// session state registers and per-word update logic
`timescale 1ns / 1ps
`default_nettype none

module phs_core
   import phs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step_en,
   input  req_word_type req_word,
   input  cfg_type      cfg,
   output rsp_word_type rsp_word
);

   phase_type            phase_ff,       phase_in;
   step_type             queued_ff,      queued_in;
   logic [COUNT_W-1:0]   frames_sent_ff, frames_sent_in;
   logic [COUNT_W-1:0]   retry_ff,       retry_in;
   logic [COUNT_W-1:0]   fps_ff,         fps_in;
   logic [TIME_W-1:0]    attempt_ff,     attempt_in;
   logic [TIME_W-1:0]    deadline_ff,    deadline_in;
   logic                 pending_ff,     pending_in;
   logic [COUNT_W-1:0]   counter_ff,     counter_in;
   logic [ADDR_W-1:0]    addr_ff,        addr_in;
   logic [CHAN_W-1:0]    chan_ff,        chan_in;
   logic                 prog_ff,        prog_in;
   logic                 acc;

   logic                 active;
   logic [COUNT_W-1:0]   sent_inc;
   logic [COUNT_W-1:0]   retry_inc;
   logic [1:0]           shift;
   logic [BACKOFF_W-1:0] shifted;
   logic [BACKOFF_W-1:0] delay;
   logic [COUNT_W-1:0]   counter_bump;

   assign active = (phase_ff == PH_PROG) || (phase_ff == PH_WAIT_UP)
                || (phase_ff == PH_CONF_UP) || (phase_ff == PH_WAIT_DOWN)
                || (phase_ff == PH_CONF_DOWN);

   assign sent_inc  = frames_sent_ff + 8'd1;
   assign retry_inc = (retry_ff < RETRY_SAT) ? retry_ff + 8'd1 : retry_ff;

   // backoff uses the incremented retry count
   assign shift   = (retry_inc < SHIFT_LIMIT) ? retry_inc[1:0] : SHIFT_CAP;
   assign shifted = {{(BACKOFF_W-GAP_W){1'b0}}, cfg.frame_gap} << shift;
   assign delay   = (shifted > cfg.backoff_cap) ? cfg.backoff_cap : shifted;

   assign counter_bump = (counter_ff >= cfg.counter_top) ? 8'd1 : counter_ff + 8'd1;

   always_comb begin
      phase_in       = phase_ff;
      queued_in      = queued_ff;
      frames_sent_in = frames_sent_ff;
      retry_in       = retry_ff;
      fps_in         = fps_ff;
      attempt_in     = attempt_ff;
      deadline_in    = deadline_ff;
      pending_in     = pending_ff;
      counter_in     = counter_ff;
      addr_in        = addr_ff;
      chan_in        = chan_ff;
      prog_in        = prog_ff;
      acc            = 1'b0;

      case (req_op_type'(req_word.req_type))
         REQ_START: begin
            if (!active && !pending_ff && req_word.sender_addr != '0
                && req_word.channel != '0 && req_word.packets != '0) begin
               pending_in     = 1'b0;
               counter_in     = 8'd1;
               addr_in        = req_word.sender_addr;
               chan_in        = req_word.channel;
               fps_in         = req_word.packets;
               deadline_in    = req_word.now_ms + req_word.session_len;
               queued_in      = STEP_PROG;
               frames_sent_in = '0;
               retry_in       = '0;
               attempt_in     = '0;
               prog_in        = 1'b1;
               phase_in       = PH_PROG;
               acc            = 1'b1;
            end
         end
         REQ_CONFIRM_UP: begin
            if (phase_ff == PH_WAIT_UP && !pending_ff) begin
               queued_in      = STEP_UP;
               frames_sent_in = '0;
               retry_in       = '0;
               attempt_in     = '0;
               prog_in        = 1'b0;
               phase_in       = PH_CONF_UP;
               acc            = 1'b1;
            end
         end
         REQ_CONFIRM_DOWN: begin
            if (phase_ff == PH_WAIT_DOWN && !pending_ff) begin
               queued_in      = STEP_DOWN;
               frames_sent_in = '0;
               retry_in       = '0;
               attempt_in     = '0;
               prog_in        = 1'b0;
               phase_in       = PH_CONF_DOWN;
               acc            = 1'b1;
            end
         end
         REQ_CANCEL: begin
            if (!(phase_ff == PH_IDLE && !pending_ff)) begin
               queued_in      = STEP_NONE;
               frames_sent_in = '0;
               retry_in       = '0;
               attempt_in     = '0;
               pending_in     = 1'b0;
               phase_in       = PH_CANCELLED;
            end
         end
         REQ_TX_COMPLETE: begin
            if (pending_ff) begin
               pending_in = 1'b0;
               if (req_word.tx_success) begin
                  retry_in       = '0;
                  frames_sent_in = sent_inc;
                  if (sent_inc < fps_ff) begin
                     attempt_in = req_word.now_ms
                                + {{(TIME_W-GAP_W){1'b0}}, cfg.frame_gap};
                  end else begin
                     // step done: drop transport, advance counter and phase
                     queued_in      = STEP_NONE;
                     frames_sent_in = '0;
                     attempt_in     = '0;
                     counter_in     = counter_bump;
                     case (phase_ff)
                        PH_PROG:      phase_in = PH_WAIT_UP;
                        PH_CONF_UP:   phase_in = PH_WAIT_DOWN;
                        PH_CONF_DOWN: phase_in = PH_COMPLETE;
                        default:      phase_in = PH_FAILED;
                     endcase
                  end
               end else begin
                  retry_in = retry_inc;
                  if (retry_inc > cfg.send_retry_limit) begin
                     queued_in      = STEP_NONE;
                     frames_sent_in = '0;
                     retry_in       = '0;
                     attempt_in     = '0;
                     phase_in       = PH_FAILED;
                  end else begin
                     attempt_in = req_word.now_ms + {{(TIME_W-BACKOFF_W){1'b0}}, delay};
                  end
               end
            end
         end
         REQ_TX_ISSUED: begin
            if (queued_ff != STEP_NONE) begin
               pending_in = 1'b1;
            end
         end
         default: begin
            acc = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         queued_ff      <= STEP_NONE;
         frames_sent_ff <= '0;
         retry_ff       <= '0;
         fps_ff         <= DEFAULT_PACKETS_RESET;
         attempt_ff     <= '0;
         deadline_ff    <= '0;
         pending_ff     <= 1'b0;
         counter_ff     <= 8'd1;
         addr_ff        <= '0;
         chan_ff        <= '0;
         prog_ff        <= 1'b1;
      end else if (step_en) begin
         phase_ff       <= phase_in;
         queued_ff      <= queued_in;
         frames_sent_ff <= frames_sent_in;
         retry_ff       <= retry_in;
         fps_ff         <= fps_in;
         attempt_ff     <= attempt_in;
         deadline_ff    <= deadline_in;
         pending_ff     <= pending_in;
         counter_ff     <= counter_in;
         addr_ff        <= addr_in;
         chan_ff        <= chan_in;
         prog_ff        <= prog_in;
      end
   end

   // the response reports the state after this word
   always_comb begin
      rsp_word.accepted        = acc;
      rsp_word.session_state   = phase_in;
      rsp_word.step_code       = queued_in;
      rsp_word.program_frame   = prog_in;
      rsp_word.frame_counter   = counter_in;
      rsp_word.next_attempt_ms = attempt_in;
      rsp_word.deadline_ms     = deadline_in;
      rsp_word.addr_out        = addr_in;
      rsp_word.channel_out     = chan_in;
   end

endmodule

`default_nettype wire

// ----- design/pairing_handshake_sequencer.sv -----
// top level of the pairing handshake sequencer: channels, registers and checks
`timescale 1ns / 1ps
`default_nettype none

// channel     dir  handshake          word
// ---------   ---  -----------------  -------------------------------------------
// req_chan    in   valid/ready        request type, time, start operands, tx result
// rsp_chan    out  valid/ready        accepted flag and session status after word
// csr_*       in   csr_we, no stall   register index and data, write only
//
// one response word per request word, one word per cycle sustained while the receiver takes every response
// a word passes the input register, then the update logic into the output register
// the session update closes its loop through the state registers
// a request is taken while a finished response waits; stalls only when both are full
// reset is synchronous and clears both stages and the session state

module pairing_handshake_sequencer
   import phs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   phs_req_if.sink                req_chan,
   phs_rsp_if.source              rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type      cfg;
   req_word_type req_word_ff, req_word_in;
   logic         req_valid_ff;
   rsp_word_type rsp_word_ff, rsp_word_in;
   logic         rsp_valid_ff;
   logic         advance;
   logic         req_take;

   // configuration registers
   phs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // word moves from input register to output register when the output is empty or its word is being taken
   assign advance  = req_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !req_valid_ff || advance;

   // gather the request word from the channel
   always_comb begin
      req_word_in.req_type    = req_chan.req_type;
      req_word_in.now_ms      = req_chan.now_ms;
      req_word_in.sender_addr = req_chan.sender_addr;
      req_word_in.channel     = req_chan.channel;
      req_word_in.packets     = req_chan.packets;
      req_word_in.session_len = req_chan.session_len;
      req_word_in.tx_success  = req_chan.tx_success;
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         req_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_word_ff <= req_word_in;
      end
   end

   // session update, state advances only with the word
   phs_core u_core (
      .clock    (clock),
      .reset    (reset),
      .step_en  (advance),
      .req_word (req_word_ff),
      .cfg      (cfg),
      .rsp_word (rsp_word_in)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.accepted        = rsp_word_ff.accepted;
   assign rsp_chan.session_state   = rsp_word_ff.session_state;
   assign rsp_chan.step_code       = rsp_word_ff.step_code;
   assign rsp_chan.program_frame   = rsp_word_ff.program_frame;
   assign rsp_chan.frame_counter   = rsp_word_ff.frame_counter;
   assign rsp_chan.next_attempt_ms = rsp_word_ff.next_attempt_ms;
   assign rsp_chan.deadline_ms     = rsp_word_ff.deadline_ms;
   assign rsp_chan.addr_out        = rsp_word_ff.addr_out;
   assign rsp_chan.channel_out     = rsp_word_ff.channel_out;

   // a taken start or confirm always leaves a step queued
   a_accept_queues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.accepted |-> rsp_word_ff.step_code != STEP_NONE)
      else $error("accepted word without a queued step");

   // a taken start or confirm lands in a sending phase
   a_accept_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.accepted |->
         rsp_word_ff.session_state == PH_PROG || rsp_word_ff.session_state == PH_CONF_UP
         || rsp_word_ff.session_state == PH_CONF_DOWN)
      else $error("accepted word outside a sending phase");

   // a held request word is not lost while the output stalls
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && !advance |=> req_valid_ff && $stable(req_word_ff))
      else $error("stalled request word dropped or changed");

   // a word that advanced shows up at the output next cycle
   a_advance_out: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced word missing at output");

endmodule

`default_nettype wire

// ----- bench/tb_pairing_handshake_sequencer.sv -----
// self-checking testbench of the pairing handshake sequencer
`timescale 1ns / 1ps

module tb_pairing_handshake_sequencer;
   import phs_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_WORDS = 210;  // per random phase, three phases
   localparam int MAX_REPORTS = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5 clock = ~clock;

   // request side: the driver owns these, the interface follows them
   logic         drv_valid = 1'b0;
   req_word_type drv_word = '0;
   logic         take_ready = 1'b0;

   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_INTER_PACKET;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   phs_req_if req_bus ();
   phs_rsp_if rsp_bus ();

   assign req_bus.valid       = drv_valid;
   assign req_bus.req_type    = drv_word.req_type;
   assign req_bus.now_ms      = drv_word.now_ms;
   assign req_bus.sender_addr = drv_word.sender_addr;
   assign req_bus.channel     = drv_word.channel;
   assign req_bus.packets     = drv_word.packets;
   assign req_bus.session_len = drv_word.session_len;
   assign req_bus.tx_success  = drv_word.tx_success;
   assign rsp_bus.ready       = take_ready;

   pairing_handshake_sequencer uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // register copies as the block should hold them
   logic [GAP_W-1:0]     cfg_gap             = INTER_PACKET_RESET;
   logic [BACKOFF_W-1:0] cfg_backoff_cap     = MAX_BACKOFF_RESET;
   logic [COUNT_W-1:0]   cfg_retry_limit     = RETRY_LIMIT_RESET;
   logic [COUNT_W-1:0]   cfg_counter_top     = COUNTER_TOP_RESET;
   // the block ignores writes to this register, so this copy is never used
   logic [COUNT_W-1:0]   cfg_default_packets = DEFAULT_PACKETS_RESET;

   // session state as the block should hold it, reset values at declaration
   phase_type          sess_phase    = PH_IDLE;
   step_type           sess_step     = STEP_NONE;
   logic [COUNT_W-1:0] sess_sent     = '0;
   logic [COUNT_W-1:0] sess_retries  = '0;
   logic [COUNT_W-1:0] sess_per_step = DEFAULT_PACKETS_RESET;
   logic [TIME_W-1:0]  sess_attempt  = '0;
   logic [TIME_W-1:0]  sess_deadline = '0;
   logic               sess_busy     = 1'b0;
   logic [COUNT_W-1:0] sess_counter  = 8'd1;
   logic [ADDR_W-1:0]  sess_addr     = '0;
   logic [CHAN_W-1:0]  sess_channel  = '0;
   logic               sess_program  = 1'b1;

   req_word_type request_backlog[$];
   rsp_word_type expected_status[$];

   int unsigned send_idle_pct = 0;
   int unsigned take_idle_pct = 0;
   int          words_queued = 0;
   int          fault_count = 0;
   int          cycle_count = 0;

   // drops whatever send is in flight
   function automatic void clear_transport();
      sess_step    = STEP_NONE;
      sess_sent    = '0;
      sess_retries = '0;
      sess_attempt = '0;
      sess_busy    = 1'b0;
   endfunction

   function automatic void queue_step(input step_type code, input phase_type nxt);
      sess_step    = code;
      sess_sent    = '0;
      sess_retries = '0;
      sess_attempt = '0;
      sess_program = (nxt == PH_PROG);
      sess_phase   = nxt;
   endfunction

   // applies one request word and returns the status word it should produce
   function automatic rsp_word_type advance_session(input req_word_type w);
      rsp_word_type     r;
      logic             taken;
      logic             active;
      logic [1:0]       shift;
      logic [TIME_W-1:0] delay;
      taken  = 1'b0;
      active = (sess_phase >= PH_PROG) && (sess_phase <= PH_CONF_DOWN);
      case (w.req_type)
         REQ_START: begin
            if (!active && !sess_busy && w.sender_addr != '0 && w.channel != '0 &&
                w.packets != '0) begin
               clear_transport();
               sess_phase    = PH_IDLE;
               sess_counter  = 8'd1;
               sess_addr     = w.sender_addr;
               sess_channel  = w.channel;
               sess_per_step = w.packets;
               sess_deadline = w.now_ms + w.session_len;
               queue_step(STEP_PROG, PH_PROG);
               taken = 1'b1;
            end
         end
         REQ_CONFIRM_UP: begin
            if (sess_phase == PH_WAIT_UP && !sess_busy) begin
               queue_step(STEP_UP, PH_CONF_UP);
               taken = 1'b1;
            end
         end
         REQ_CONFIRM_DOWN: begin
            if (sess_phase == PH_WAIT_DOWN && !sess_busy) begin
               queue_step(STEP_DOWN, PH_CONF_DOWN);
               taken = 1'b1;
            end
         end
         REQ_CANCEL: begin
            // idle and not busy: nothing to cancel
            if (!(sess_phase == PH_IDLE && !sess_busy)) begin
               clear_transport();
               sess_phase = PH_CANCELLED;
            end
         end
         REQ_TX_COMPLETE: begin
            if (sess_busy) begin
               sess_busy = 1'b0;
               if (w.tx_success) begin
                  sess_retries = '0;
                  sess_sent    = sess_sent + 1'b1;
                  if (sess_sent < sess_per_step) begin
                     sess_attempt = w.now_ms + TIME_W'(cfg_gap);
                  end else begin
                     // step done: bump the rolling counter and move on
                     clear_transport();
                     if (sess_counter >= cfg_counter_top) sess_counter = 8'd1;
                     else sess_counter = sess_counter + 1'b1;
                     case (sess_phase)
                        PH_PROG:      sess_phase = PH_WAIT_UP;
                        PH_CONF_UP:   sess_phase = PH_WAIT_DOWN;
                        PH_CONF_DOWN: sess_phase = PH_COMPLETE;
                        default:      sess_phase = PH_FAILED;
                     endcase
                  end
               end else begin
                  if (sess_retries < RETRY_SAT) sess_retries = sess_retries + 1'b1;
                  if (sess_retries > cfg_retry_limit) begin
                     clear_transport();
                     sess_phase = PH_FAILED;
                  end else begin
                     // exponential backoff, shift capped, delay capped
                     shift = (sess_retries < SHIFT_LIMIT) ? sess_retries[1:0] : SHIFT_CAP;
                     delay = TIME_W'(cfg_gap) << shift;
                     if (delay > TIME_W'(cfg_backoff_cap)) delay = TIME_W'(cfg_backoff_cap);
                     sess_attempt = w.now_ms + delay;
                  end
               end
            end
         end
         REQ_TX_ISSUED: begin
            if (sess_step != STEP_NONE) sess_busy = 1'b1;
         end
         default: ;
      endcase
      r.accepted        = taken;
      r.session_state   = sess_phase;
      r.step_code       = sess_step;
      r.program_frame   = sess_program;
      r.frame_counter   = sess_counter;
      r.next_attempt_ms = sess_attempt;
      r.deadline_ms     = sess_deadline;
      r.addr_out        = sess_addr;
      r.channel_out     = sess_channel;
      return r;
   endfunction

   function automatic string show_status(input rsp_word_type s);
      return $sformatf("acc %0d state %0d step %0d prog %0d cnt %0d next %h dl %h addr %h ch %h",
                       s.accepted, s.session_state, s.step_code, s.program_frame,
                       s.frame_counter, s.next_attempt_ms, s.deadline_ms, s.addr_out,
                       s.channel_out);
   endfunction

   // driver: predicts each word as it is taken, then loads the next one
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         drv_valid <= 1'b0;
      end else begin
         if (drv_valid && req_bus.ready) expected_status.push_back(advance_session(drv_word));
         if (!drv_valid || req_bus.ready) begin
            if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               drv_word  <= request_backlog.pop_front();
               drv_valid <= 1'b1;
            end else begin
               drv_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: random back-pressure, every taken status word checked field by field
   always @(posedge clock) begin
      rsp_word_type got;
      rsp_word_type want;
      string        diffs;
      take_ready <= ($urandom_range(99) >= take_idle_pct);
      if (!reset && rsp_bus.valid && take_ready) begin
         got.accepted        = rsp_bus.accepted;
         got.session_state   = phase_type'(rsp_bus.session_state);
         got.step_code       = step_type'(rsp_bus.step_code);
         got.program_frame   = rsp_bus.program_frame;
         got.frame_counter   = rsp_bus.frame_counter;
         got.next_attempt_ms = rsp_bus.next_attempt_ms;
         got.deadline_ms     = rsp_bus.deadline_ms;
         got.addr_out        = rsp_bus.addr_out;
         got.channel_out     = rsp_bus.channel_out;
         if (expected_status.size() == 0) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS)
               $display("status word with nothing expected: %s", show_status(got));
         end else begin
            want  = expected_status.pop_front();
            diffs = "";
            if (got.accepted !== want.accepted) diffs = {diffs, " accepted"};
            if (got.session_state !== want.session_state) diffs = {diffs, " session_state"};
            if (got.step_code !== want.step_code) diffs = {diffs, " step_code"};
            if (got.program_frame !== want.program_frame) diffs = {diffs, " program_frame"};
            if (got.frame_counter !== want.frame_counter) diffs = {diffs, " frame_counter"};
            if (got.next_attempt_ms !== want.next_attempt_ms) diffs = {diffs, " next_attempt_ms"};
            if (got.deadline_ms !== want.deadline_ms) diffs = {diffs, " deadline_ms"};
            if (got.addr_out !== want.addr_out) diffs = {diffs, " addr_out"};
            if (got.channel_out !== want.channel_out) diffs = {diffs, " channel_out"};
            if (diffs != "") begin
               fault_count++;
               if (fault_count <= MAX_REPORTS)
                  $display("mismatch at %0t on%s\n  expected %s\n  actual   %s", $realtime,
                           diffs, show_status(want), show_status(got));
            end
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_pairing_handshake_sequencer: errors");
         $finish;
      end
   end

   // random word of a given code, every field random
   function automatic req_word_type rand_word(input logic [REQ_TYPE_W-1:0] code);
      req_word_type w;
      w.req_type    = code;
      w.now_ms      = $urandom;
      w.sender_addr = ADDR_W'($urandom);
      w.channel     = CHAN_W'($urandom);
      w.packets     = COUNT_W'($urandom);
      w.session_len = $urandom;
      w.tx_success  = 1'($urandom_range(1));
      return w;
   endfunction

   function automatic req_word_type start_word(input logic [ADDR_W-1:0] addr,
                                               input logic [CHAN_W-1:0] chan,
                                               input logic [COUNT_W-1:0] count);
      req_word_type w;
      w             = rand_word(REQ_START);
      w.sender_addr = addr;
      w.channel     = chan;
      w.packets     = count;
      return w;
   endfunction

   function automatic req_word_type tx_done(input logic ok);
      req_word_type w;
      w            = rand_word(REQ_TX_COMPLETE);
      w.tx_success = ok;
      return w;
   endfunction

   // noise words do not count toward the phase size
   task automatic queue_word(input req_word_type w, input bit counted);
      request_backlog.push_back(w);
      if (counted) words_queued++;
   endtask

   // a well-formed session with random content, failed sends and stray words
   task automatic queue_session();
      req_word_type w;
      int           frames;
      int           tries;
      frames = ($urandom_range(15) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 3);
      w = start_word(ADDR_W'($urandom_range(1, 24'hFFFFFF)), CHAN_W'($urandom_range(1, 255)),
                     COUNT_W'(frames));
      queue_word(w, 1'b1);
      for (int s = 0; s < 3; s++) begin
         if (s == 1) queue_word(rand_word(REQ_CONFIRM_UP), 1'b1);
         if (s == 2) queue_word(rand_word(REQ_CONFIRM_DOWN), 1'b1);
         for (int f = 0; f < frames; f++) begin
            tries = 0;
            do begin
               if ($urandom_range(99) < 6)
                  queue_word(rand_word(REQ_TYPE_W'($urandom_range(7))), 1'b0);
               queue_word(rand_word(REQ_TX_ISSUED), 1'b1);
               w = tx_done(($urandom_range(99) >= 15) || tries >= 5);
               queue_word(w, 1'b1);
               tries++;
            end while (!w.tx_success);
         end
      end
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_INTER_PACKET:    cfg_gap             = data[GAP_W-1:0];
         CSR_MAX_BACKOFF:     cfg_backoff_cap     = data[BACKOFF_W-1:0];
         CSR_RETRY_LIMIT:     cfg_retry_limit     = data[COUNT_W-1:0];
         CSR_COUNTER_TOP:     cfg_counter_top     = data[COUNT_W-1:0];
         CSR_DEFAULT_PACKETS: cfg_default_packets = data[COUNT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic load_settings(input logic [GAP_W-1:0] gap, input logic [BACKOFF_W-1:0] cap,
                                input logic [COUNT_W-1:0] retries,
                                input logic [COUNT_W-1:0] cmax,
                                input logic [COUNT_W-1:0] dflt);
      write_reg(CSR_INTER_PACKET, CSR_DATA_W'(gap));
      write_reg(CSR_MAX_BACKOFF, CSR_DATA_W'(cap));
      write_reg(CSR_RETRY_LIMIT, CSR_DATA_W'(retries));
      write_reg(CSR_COUNTER_TOP, CSR_DATA_W'(cmax));
      write_reg(CSR_DEFAULT_PACKETS, CSR_DATA_W'(dflt));
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // wait until every word is taken and every status word checked, then settle
   task automatic drain();
      @(negedge clock);
      while (request_backlog.size() != 0 || drv_valid || expected_status.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic run_random_phase(input int unsigned send_pct, input int unsigned take_pct);
      @(negedge clock);
      send_idle_pct = send_pct;
      take_idle_pct = take_pct;
      words_queued  = 0;
      while (words_queued < RANDOM_WORDS) queue_session();
      drain();
   endtask

   initial begin
      req_word_type w;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: capped backoff, counter max of zero always wraps to one
      load_settings(16'd300, 19'd1000, 8'd3, 8'd0, 8'd2);
      @(negedge clock);
      send_idle_pct = 9;
      take_idle_pct = 86;
      // stray words in idle are ignored
      queue_word(rand_word(REQ_TX_ISSUED), 1'b1);
      queue_word(tx_done(1'b1), 1'b1);
      queue_word(rand_word(REQ_CANCEL), 1'b1);
      // a zero operand rejects start
      queue_word(start_word('0, 8'd9, 8'd1), 1'b1);
      queue_word(start_word(24'd1, '0, 8'd1), 1'b1);
      queue_word(start_word(24'd1, 8'd1, '0), 1'b1);
      // all-ones start, deadline wraps
      w = start_word('1, '1, 8'd1);
      w.now_ms = '1;
      w.session_len = '1;
      queue_word(w, 1'b1);
      // start while active, then while busy; confirm in wrong phase while busy
      queue_word(start_word(24'd5, 8'd5, 8'd5), 1'b1);
      queue_word(rand_word(REQ_TX_ISSUED), 1'b1);
      queue_word(start_word(24'd6, 8'd6, 8'd6), 1'b1);
      queue_word(rand_word(REQ_CONFIRM_DOWN), 1'b1);
      // failed sends: backoff grows, hits the cap, then the session fails
      queue_word(tx_done(1'b0), 1'b1);
      repeat (3) begin
         queue_word(rand_word(REQ_TX_ISSUED), 1'b1);
         queue_word(tx_done(1'b0), 1'b1);
      end
      // fresh session from failed, all-zero time fields
      w = start_word(24'd1, 8'd1, 8'd1);
      w.now_ms = '0;
      w.session_len = '0;
      queue_word(w, 1'b1);
      queue_word(rand_word(REQ_TX_ISSUED), 1'b1);
      queue_word(tx_done(1'b1), 1'b1);
      queue_word(rand_word(3'd7), 1'b1);  // unused code
      queue_word(rand_word(REQ_CONFIRM_UP), 1'b1);
      queue_word(rand_word(REQ_TX_ISSUED), 1'b1);
      queue_word(rand_word(REQ_CANCEL), 1'b1);  // cancel while busy
      drain();

      // high extremes, receiver mostly stalled
      load_settings('1, '1, 8'd254, 8'd255, 8'd255);
      run_random_phase(9, 86);

      // low extremes, sender mostly idle
      load_settings('0, '0, 8'd0, 8'd1, 8'd1);
      run_random_phase(86, 9);

      // random settings, small counter max for frequent wraps, no idling
      load_settings(GAP_W'($urandom), BACKOFF_W'($urandom), COUNT_W'($urandom_range(1, 6)),
                    COUNT_W'($urandom_range(2, 5)), COUNT_W'($urandom_range(1, 255)));
      run_random_phase(0, 0);

      if (fault_count == 0 && expected_status.size() == 0)
         $display("tb_pairing_handshake_sequencer: clean");
      else
         $display("tb_pairing_handshake_sequencer: errors");
      $finish;
   end

endmodule
